/* hdl/assert_macros.svh */
// assertion macros used by the top level of the blur block
// expects clk and rst_n to be visible where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that holds on every clock edge out of reset
`define ASSERT_CLK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/rgbm_pkg.sv */
// shared types and constants of the eight-neighbour mean blur
// no dependencies
package rgbm_pkg;

  localparam int PIX_W     = 8;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int SUM_W     = PIX_W + 3;

  // register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic [CFG_W-1:0] FRAME_DIM_RESET = 11'd256;
  localparam logic [CFG_W-1:0] MIN_DIM         = 11'd2;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } rgb_t;

  // what the back end does with one queued item
  typedef struct packed {
    logic emit;       // item produces a result
    logic top_rep;    // replicate middle row into top row
    logic bot_rep;    // replicate middle row into bottom row
    logic left_rep;   // replicate centre column into left column
    logic right_rep;  // replicate centre column into right column
    logic last;       // result closes the frame
  } emit_ctl_t;

  typedef struct packed {
    logic at_frame_start;
    logic draining;
  } front_stat_t;

endpackage

/* hdl/rgbm_if.sv */
// handshake channels of the blur block: pixel in, result out, register write
// depends on rgbm_pkg
interface rgbm_in_if import rgbm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [PIX_W-1:0] in_red;
  logic [PIX_W-1:0] in_green;
  logic [PIX_W-1:0] in_blue;
  modport source (output valid, cmd, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, cmd, in_red, in_green, in_blue, output ready);
endinterface

interface rgbm_out_if import rgbm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] out_red;
  logic [PIX_W-1:0] out_green;
  logic [PIX_W-1:0] out_blue;
  logic             frame_last;
  modport source (output valid, out_red, out_green, out_blue, frame_last, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, frame_last, output ready);
endinterface

interface rgbm_cfg_if import rgbm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/rgbm_front.sv */
// front end: accepts items, tracks raster position, classifies each item
// depends on rgbm_pkg and rgbm_in_if
module rgbm_front import rgbm_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int RW = $clog2(MAX_HEIGHT + 2)
) (
  input  logic              clk,
  input  logic              rst_n,
  rgbm_in_if.sink           in_bus,
  input  logic [CFG_W-1:0]  frame_width,
  input  logic [CFG_W-1:0]  frame_height,
  input  logic              restart,
  input  logic              q_full,
  output logic              push,
  output logic [CW-1:0]     push_col,
  output rgb_t              push_pix,
  output emit_ctl_t         push_ctl,
  output front_stat_t       stat
);

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic draining, accept, drop, case_a, case_b, row_end;

  always_comb begin
    draining = 32'(row_r) >= 32'(frame_height);
    in_bus.ready = !q_full;
    accept = in_bus.valid && in_bus.ready;
    drop = !draining && in_bus.cmd;
    push = accept && !drop;

    // start of a row closes the last column of the row two above
    case_a = (col_r == '0) && (32'(row_r) >= 32'd2);
    case_b = (col_r != '0) && (32'(row_r) >= 32'd1);
    row_end = (32'(col_r) + 32'd1) == 32'(frame_width);

    push_ctl.emit      = case_a || case_b;
    push_ctl.top_rep   = case_a ? (32'(row_r) == 32'd2) : (32'(row_r) == 32'd1);
    push_ctl.bot_rep   = case_a ? (32'(row_r) > 32'(frame_height))
                                : (32'(row_r) >= 32'(frame_height));
    push_ctl.left_rep  = case_b && (32'(col_r) == 32'd1);
    push_ctl.right_rep = case_a;
    push_ctl.last      = case_a && (32'(row_r) == 32'(frame_height) + 32'd1);

    push_col = col_r;
    if (draining) begin
      push_pix = '0;
    end else begin
      push_pix = '{red: in_bus.in_red, green: in_bus.in_green, blue: in_bus.in_blue};
    end

    col_nxt = col_r;
    row_nxt = row_r;
    if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (push) begin
      if (push_ctl.last) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (row_end) begin
        col_nxt = '0;
        row_nxt = row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end

    stat.at_frame_start = (col_r == '0) && (row_r == '0);
    stat.draining = draining;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

/* hdl/rgbm_fifo.sv */
// two-entry queue between the front and back ends
// depends on nothing
module rgbm_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] head
);

  logic [WIDTH-1:0] slot_r [2];
  logic wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full  = count_r == 2'd2;
  assign valid = count_r != 2'd0;
  assign head  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* hdl/rgbm_back.sv */
// back end: line stores, 3x3 window, neighbour sum and output register
// depends on rgbm_pkg and rgbm_out_if
module rgbm_back import rgbm_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  logic [CW-1:0] q_col,
  input  rgb_t          q_pix,
  input  emit_ctl_t     q_ctl,
  output logic          q_pop,
  rgbm_out_if.source    out_bus
);

  rgb_t upper_mem  [MAX_WIDTH];
  rgb_t middle_mem [MAX_WIDTH];

  // read stage
  logic          s2_valid_r;
  logic [CW-1:0] s2_col_r;
  rgb_t          s2_pix_r;
  emit_ctl_t     s2_ctl_r;
  rgb_t          upper_rd_r, middle_rd_r;

  // sum stage
  logic      s3_valid_r;
  emit_ctl_t s3_ctl_r;
  rgb_t      window_r [3][3];

  logic out_valid_r;
  rgb_t out_pix_r;
  logic out_last_r;

  logic out_free, s3_move, s3_free, s2_retire, s2_free;
  rgb_t row_t [3];
  rgb_t row_b [3];
  rgb_t tl, tc, tr, ml, mr, bl, bc, br;
  rgb_t mean;

  function automatic logic [PIX_W-1:0] mean8(
    input logic [PIX_W-1:0] a, b, c, d, e, f, g, h
  );
    logic [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(b) + SUM_W'(c) + SUM_W'(d)
      + SUM_W'(e) + SUM_W'(f) + SUM_W'(g) + SUM_W'(h);
    return s[SUM_W-1:3];
  endfunction

  always_comb begin
    out_free  = !out_valid_r || out_bus.ready;
    s3_move   = s3_valid_r && out_free;
    s3_free   = !s3_valid_r || s3_move;
    s2_retire = s2_valid_r && s3_free;
    s2_free   = !s2_valid_r || s2_retire;
    q_pop     = q_valid && s2_free;

    // border replication picks rows, then columns
    for (int c = 0; c < 3; c++) begin
      row_t[c] = s3_ctl_r.top_rep ? window_r[1][c] : window_r[0][c];
      row_b[c] = s3_ctl_r.bot_rep ? window_r[1][c] : window_r[2][c];
    end
    tl = s3_ctl_r.left_rep  ? row_t[1] : row_t[0];
    tc = row_t[1];
    tr = s3_ctl_r.right_rep ? row_t[1] : row_t[2];
    ml = s3_ctl_r.left_rep  ? window_r[1][1] : window_r[1][0];
    mr = s3_ctl_r.right_rep ? window_r[1][1] : window_r[1][2];
    bl = s3_ctl_r.left_rep  ? row_b[1] : row_b[0];
    bc = row_b[1];
    br = s3_ctl_r.right_rep ? row_b[1] : row_b[2];

    mean.red   = mean8(tl.red, tc.red, tr.red, ml.red, mr.red, bl.red, bc.red, br.red);
    mean.green = mean8(tl.green, tc.green, tr.green, ml.green, mr.green,
                       bl.green, bc.green, br.green);
    mean.blue  = mean8(tl.blue, tc.blue, tr.blue, ml.blue, mr.blue,
                       bl.blue, bc.blue, br.blue);

    out_bus.valid      = out_valid_r;
    out_bus.out_red    = out_pix_r.red;
    out_bus.out_green  = out_pix_r.green;
    out_bus.out_blue   = out_pix_r.blue;
    out_bus.frame_last = out_last_r;
  end

  // line stores: read on pop, write on retire (column rolls up a row)
  always_ff @(posedge clk) begin
    if (q_pop) begin
      upper_rd_r  <= upper_mem[q_col];
      middle_rd_r <= middle_mem[q_col];
    end
    if (s2_retire) begin
      upper_mem[s2_col_r]  <= middle_rd_r;
      middle_mem[s2_col_r] <= s2_pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s2_col_r <= q_col;
      s2_pix_r <= q_pix;
      s2_ctl_r <= q_ctl;
    end
    if (s2_retire) begin
      s3_ctl_r <= s2_ctl_r;
    end
    if (s3_move) begin
      out_pix_r  <= mean;
      out_last_r <= s3_ctl_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          window_r[r][c] <= '0;
        end
      end
    end else begin
      if (q_pop) begin
        s2_valid_r <= 1'b1;
      end else if (s2_retire) begin
        s2_valid_r <= 1'b0;
      end

      if (s2_retire) begin
        s3_valid_r <= s2_ctl_r.emit;
        for (int r = 0; r < 3; r++) begin
          window_r[r][0] <= window_r[r][1];
          window_r[r][1] <= window_r[r][2];
        end
        window_r[0][2] <= upper_rd_r;
        window_r[1][2] <= middle_rd_r;
        window_r[2][2] <= s2_pix_r;
      end else if (s3_move) begin
        s3_valid_r <= 1'b0;
      end

      if (s3_move) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

/* hdl/rgb_eight_neighbour_mean_blur.sv */
// top level of the eight-neighbour mean blur: config registers, front, queue, back
// depends on rgbm_pkg, rgbm_if, rgbm_front, rgbm_fifo, rgbm_back, assert_macros.svh
//
// Takes an RGB frame in raster order, one pixel item per clock while ready is high,
// and returns for every pixel the per-channel sum of its eight 3x3 neighbours (centre
// excluded) shifted right by 3. Outside the image the nearest edge pixel is used, row
// and column clamped separately. The result of a pixel comes out with the input item
// one row plus one pixel later, so after the last pixel the source sends frame_width+1
// flush items (cmd = 1; a pixel sent then counts as a flush) to drain the frame; a
// flush inside the frame is swallowed. frame_last marks the final result, and the next
// item starts a new frame. Sustained rate is one item per clock without backpressure:
// the front end only updates the column/row counters, and each line store does one
// read and one write per item. An accepted item passes the queue, read stage and sum
// stage before reaching the output register. Writing frame_width (index 0) or
// frame_height (index 1) restarts the frame; values are clamped to [2, MAX_WIDTH] and
// [2, MAX_HEIGHT], other indexes are ignored. Line stores come up with undefined
// contents and need no clearing: no result ever uses an entry not yet written.
`include "assert_macros.svh"

module rgb_eight_neighbour_mean_blur import rgbm_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  rgbm_in_if.sink     in_bus,
  rgbm_out_if.source  out_bus,
  rgbm_cfg_if.sink    cfg_bus
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int REC_W = CW + $bits(rgb_t) + $bits(emit_ctl_t);

  // reset size, clamped like a register write
  localparam logic [CFG_W-1:0] WIDTH_RESET  =
    (MAX_WIDTH < 256) ? CFG_W'(MAX_WIDTH) : FRAME_DIM_RESET;
  localparam logic [CFG_W-1:0] HEIGHT_RESET =
    (MAX_HEIGHT < 256) ? CFG_W'(MAX_HEIGHT) : FRAME_DIM_RESET;

  logic [CFG_W-1:0] frame_width_r, frame_width_nxt;
  logic [CFG_W-1:0] frame_height_r, frame_height_nxt;
  logic cfg_we, restart;

  // front to queue
  logic          push;
  logic [CW-1:0] push_col;
  rgb_t          push_pix;
  emit_ctl_t     push_ctl;
  front_stat_t   front_stat;
  logic          q_full;

  // queue to back
  logic             q_valid, q_pop;
  logic [REC_W-1:0] q_head;
  logic [CW-1:0]    q_col;
  rgb_t             q_pix;
  emit_ctl_t        q_ctl;

  function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v, input int hi);
    if (v < MIN_DIM) begin
      return MIN_DIM;
    end
    if (32'(v) > hi) begin
      return CFG_W'(hi);
    end
    return v;
  endfunction

  // register writes are always taken
  always_comb begin
    cfg_bus.ready = 1'b1;
    cfg_we = cfg_bus.valid && cfg_bus.ready;
    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    restart = 1'b0;
    if (cfg_we) begin
      if (cfg_bus.index == REG_FRAME_WIDTH) begin
        frame_width_nxt = clamp_dim(cfg_bus.data, MAX_WIDTH);
        restart = 1'b1;
      end else if (cfg_bus.index == REG_FRAME_HEIGHT) begin
        frame_height_nxt = clamp_dim(cfg_bus.data, MAX_HEIGHT);
        restart = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= WIDTH_RESET;
      frame_height_r <= HEIGHT_RESET;
    end else begin
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
    end
  end

  // position tracking and classification of each item
  rgbm_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_bus       (in_bus),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .restart      (restart),
    .q_full       (q_full),
    .push         (push),
    .push_col     (push_col),
    .push_pix     (push_pix),
    .push_ctl     (push_ctl),
    .stat         (front_stat)
  );

  // decouples input acceptance from output backpressure
  rgbm_fifo #(
    .WIDTH (REC_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_col, push_pix, push_ctl}),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  assign {q_col, q_pix, q_ctl} = q_head;

  // line stores, window and the neighbour sum
  rgbm_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_col   (q_col),
    .q_pix   (q_pix),
    .q_ctl   (q_ctl),
    .q_pop   (q_pop),
    .out_bus (out_bus)
  );

  // the queue never takes an item it has no room for
  `ASSERT_IMPL(a_no_overflow, push, !q_full, "item pushed into a full queue")
  // closing the frame puts the counters back at the origin
  `ASSERT_NEXT(a_last_restarts, push && push_ctl.last, front_stat.at_frame_start,
               "frame did not restart after its last result")
  // while draining every item goes through to the back end
  `ASSERT_IMPL(a_drain_no_drop, in_bus.valid && in_bus.ready && front_stat.draining, push,
               "item lost while draining")
  `ASSERT_CLK(a_dims_legal, frame_width_r >= MIN_DIM && frame_height_r >= MIN_DIM,
              "frame size below minimum")

endmodule
